>>> rtl/sct_pkg.sv
// shared types, mode and kind codes, and character constants of the shell command tokenizer
package sct_pkg;

    // lexer modes
    localparam logic [2:0] MODE_IDLE      = 3'd0;
    localparam logic [2:0] MODE_WORD      = 3'd1;
    localparam logic [2:0] MODE_WORD_ESC  = 3'd2;
    localparam logic [2:0] MODE_QUOTE     = 3'd3;
    localparam logic [2:0] MODE_QUOTE_ESC = 3'd4;
    localparam logic [2:0] MODE_PEND_PIPE = 3'd5;
    localparam logic [2:0] MODE_PEND_AMP  = 3'd6;

    // result kinds
    localparam logic [2:0] K_CHAR   = 3'd0;
    localparam logic [2:0] K_STREND = 3'd1;
    localparam logic [2:0] K_PIPE   = 3'd2;
    localparam logic [2:0] K_OR     = 3'd3;
    localparam logic [2:0] K_AND    = 3'd4;
    localparam logic [2:0] K_BG     = 3'd5;
    localparam logic [2:0] K_EOL    = 3'd6;
    localparam logic [2:0] K_SEMI   = 3'd7;

    // character codes
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] char_value;
        logic [8:0] token_length;
        logic       overflow;
        logic       last;
    } result_t;

    // up to two result words caused by one character
    typedef struct packed {
        logic [1:0] count;
        result_t    word0;
        result_t    word1;
    } lex_out_t;

    function automatic logic is_word_char(input logic [7:0] c);
        logic lower;
        logic upper;
        logic digit;
        lower = (c >= 8'h61) && (c <= 8'h7A);
        upper = (c >= 8'h41) && (c <= 8'h5A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        return lower || upper || digit || (c == CH_SLASH) || (c == CH_DOT) || (c == CH_EQ);
    endfunction

endpackage

>>> rtl/sct_lexer.sv
// lexer state and next-state logic: one character in, up to two result words out
module sct_lexer
    import sct_pkg::*;
#(
    parameter int TOKEN_CAPACITY = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_in,
    output lex_out_t   lex_out
);

    localparam int LW = $clog2(TOKEN_CAPACITY + 1);
    localparam logic [LW-1:0] CAP_L = LW'(TOKEN_CAPACITY);

    logic [2:0]    mode_reg;
    logic [2:0]    mode_next;
    logic          qsingle_reg;
    logic          qsingle_next;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic          ovf_reg;
    logic          ovf_next;

    // handling of a character with no token open
    logic [2:0]    idle_mode;
    logic          idle_q;
    logic [LW-1:0] idle_len;
    logic          idle_ovf;
    logic          idle_has;
    result_t       idle_word;

    logic          can_push;
    logic [LW-1:0] push_len;
    result_t       char_word;
    result_t       strend_word;
    logic [7:0]    close_quote;

    logic          lead_has;
    result_t       lead;
    logic          tail_has;
    result_t       tail;
    logic [1:0]    count;

    assign can_push    = len_reg < CAP_L;
    assign push_len    = len_reg + LW'(1);
    assign char_word   = '{kind: K_CHAR, char_value: char_in, token_length: 9'd0,
                           overflow: 1'b0, last: 1'b0};
    assign strend_word = '{kind: K_STREND, char_value: 8'd0, token_length: 9'(len_reg),
                           overflow: ovf_reg, last: 1'b0};
    assign close_quote = qsingle_reg ? CH_SQUOTE : CH_DQUOTE;

    // character outside any token
    always_comb
    begin
        idle_mode = MODE_IDLE;
        idle_q    = qsingle_reg;
        idle_len  = len_reg;
        idle_ovf  = ovf_reg;
        idle_has  = 1'b0;
        idle_word = char_word;
        if (char_in == CH_PIPE)
        begin
            idle_mode = MODE_PEND_PIPE;
        end
        else if (char_in == CH_AMP)
        begin
            idle_mode = MODE_PEND_AMP;
        end
        else if (char_in == CH_NL)
        begin
            idle_has       = 1'b1;
            idle_word      = '0;
            idle_word.kind = K_EOL;
        end
        else if (char_in == CH_SEMI)
        begin
            idle_has       = 1'b1;
            idle_word      = '0;
            idle_word.kind = K_SEMI;
        end
        else if (is_word_char(char_in))
        begin
            // a fresh token always has room for its first character
            idle_mode = MODE_WORD;
            idle_len  = LW'(1);
            idle_ovf  = 1'b0;
            idle_has  = 1'b1;
        end
        else if (char_in == CH_BSLASH)
        begin
            idle_mode = MODE_WORD_ESC;
            idle_len  = '0;
            idle_ovf  = 1'b0;
        end
        else if ((char_in == CH_DQUOTE) || (char_in == CH_SQUOTE))
        begin
            idle_mode = MODE_QUOTE;
            idle_q    = (char_in == CH_SQUOTE);
            idle_len  = '0;
            idle_ovf  = 1'b0;
        end
    end

    // mode decoder
    always_comb
    begin
        mode_next    = mode_reg;
        qsingle_next = qsingle_reg;
        len_next     = len_reg;
        ovf_next     = ovf_reg;
        lead_has     = 1'b0;
        lead         = strend_word;
        tail_has     = 1'b0;
        tail         = char_word;
        unique case (mode_reg)
            MODE_WORD:
            begin
                if (is_word_char(char_in))
                begin
                    if (can_push)
                    begin
                        tail_has = 1'b1;
                        len_next = push_len;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                else if (char_in == CH_BSLASH)
                begin
                    mode_next = MODE_WORD_ESC;
                end
                else
                begin
                    // word ends, then the character starts over
                    lead_has     = 1'b1;
                    mode_next    = idle_mode;
                    qsingle_next = idle_q;
                    len_next     = idle_len;
                    ovf_next     = idle_ovf;
                    tail_has     = idle_has;
                    tail         = idle_word;
                end
            end
            MODE_WORD_ESC, MODE_QUOTE_ESC:
            begin
                mode_next = (mode_reg == MODE_WORD_ESC) ? MODE_WORD : MODE_QUOTE;
                if (can_push)
                begin
                    tail_has = 1'b1;
                    len_next = push_len;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            MODE_QUOTE:
            begin
                if (char_in == CH_BSLASH)
                begin
                    mode_next = MODE_QUOTE_ESC;
                end
                else if (char_in == close_quote)
                begin
                    mode_next = MODE_IDLE;
                    tail_has  = 1'b1;
                    tail      = strend_word;
                end
                else if (can_push)
                begin
                    tail_has = 1'b1;
                    len_next = push_len;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            MODE_PEND_PIPE, MODE_PEND_AMP:
            begin
                if (((mode_reg == MODE_PEND_PIPE) && (char_in == CH_PIPE)) ||
                    ((mode_reg == MODE_PEND_AMP) && (char_in == CH_AMP)))
                begin
                    mode_next = MODE_IDLE;
                    tail_has  = 1'b1;
                    tail      = '0;
                    tail.kind = (mode_reg == MODE_PEND_PIPE) ? K_OR : K_AND;
                end
                else
                begin
                    lead_has     = 1'b1;
                    lead         = '0;
                    lead.kind    = (mode_reg == MODE_PEND_PIPE) ? K_PIPE : K_BG;
                    mode_next    = idle_mode;
                    qsingle_next = idle_q;
                    len_next     = idle_len;
                    ovf_next     = idle_ovf;
                    tail_has     = idle_has;
                    tail         = idle_word;
                end
            end
            default:
            begin
                mode_next    = idle_mode;
                qsingle_next = idle_q;
                len_next     = idle_len;
                ovf_next     = idle_ovf;
                tail_has     = idle_has;
                tail         = idle_word;
            end
        endcase
    end

    // pack the result words, last flag on the final one
    assign count = {1'b0, lead_has} + {1'b0, tail_has};
    always_comb
    begin
        lex_out.count      = count;
        lex_out.word0      = lead_has ? lead : tail;
        lex_out.word0.last = (count == 2'd1);
        lex_out.word1      = tail;
        lex_out.word1.last = 1'b1;
    end

    // lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            qsingle_reg <= 1'b0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            qsingle_reg <= qsingle_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
        end
    end

endmodule

>>> rtl/sct_res_fifo.sv
// result queue: takes up to two words per cycle, hands out one word per cycle while head_ready is high
module sct_res_fifo
    import sct_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lex_out_t push_data,
    output logic     room,
    output logic     head_valid,
    input  logic     head_ready,
    output result_t  head
);

    result_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [1:0]       push_cnt;
    logic             pop;

    assign push_cnt   = push ? push_data.count : 2'd0;
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign pop        = head_valid && head_ready;
    assign room       = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign cnt_next    = cnt_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data.word0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push_data.word1;
        end
    end

endmodule

>>> rtl/shell_command_tokenizer.sv
// top level of the shell command tokenizer: input register, lexer, result queue
//
// Takes one command-line character per word on the input channel and hands out shell
// tokens as result words: token characters, string ends with length and overflow, and
// the operators pipe, or, background, and, end of line and semicolon. A character is
// accepted in every cycle while the four-word result queue has room for two words;
// the first result word is offered on the output once the character has passed the
// input register and has been written into the result queue. Each result word is handed
// out on its own on the output port, and a character that causes none (outside a token:
// blanks, the first | or &, a backslash, an opening quote) adds nothing to the output.
// The queue drain of one word per cycle while out_ready is high sets the sustained
// rate. Word and quoted-string lengths count up to TOKEN_CAPACITY; further characters
// are dropped and flagged on the string end.
module shell_command_tokenizer
    import sct_pkg::*;
#(
    parameter int TOKEN_CAPACITY = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] kind,
    output logic [7:0] char_value,
    output logic [8:0] token_length,
    output logic       overflow,
    output logic       last
);

    logic       in_valid_reg;
    logic [7:0] char_reg;
    logic       room;
    logic       step;
    lex_out_t   lex_out;
    result_t    head;

    assign step     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || step;

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input character
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_in;
        end
    end

    sct_lexer #(
        .TOKEN_CAPACITY (TOKEN_CAPACITY)
    ) u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .char_in (char_reg),
        .lex_out (lex_out)
    );

    sct_res_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_data  (lex_out),
        .room       (room),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    // result word fields
    assign kind         = head.kind;
    assign char_value   = head.char_value;
    assign token_length = head.token_length;
    assign overflow     = head.overflow;
    assign last         = head.last;

endmodule

>>> rtl/sct_checker.sv
// port checker for the shell command tokenizer, bound to the top level
module sct_checker
    import sct_pkg::*;
#(
    parameter int TOKEN_CAPACITY = 256
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] char_in,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind,
    input logic [7:0] char_value,
    input logic [8:0] token_length,
    input logic       overflow,
    input logic       last
);

    // a stalled input word stays offered with the same character
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(char_in))
        else $error("input word withdrawn or changed while stalled");

    // a stalled result word stays offered and keeps its fields
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(char_value) &&
            $stable(token_length) && $stable(overflow) && $stable(last))
        else $error("result word withdrawn or changed while stalled");

    // only token characters carry a character value
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != K_CHAR) |-> (char_value == 8'd0))
        else $error("character value on a non-character word");

    // length and overflow belong to string ends only
    a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != K_STREND) |-> (token_length == 9'd0) && !overflow)
        else $error("length or overflow on a word that is not a string end");

    // an overflowed string reports a full length
    a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> (token_length == 9'(TOKEN_CAPACITY)))
        else $error("overflow flagged without a full length");

endmodule

bind shell_command_tokenizer sct_checker #(
    .TOKEN_CAPACITY (TOKEN_CAPACITY)
) u_sct_checker (.*);
